// ===== rtl/sharpen_3x3_cross_stream_core_macros.svh =====
// Assertion macros shared by the sharpen core RTL.
// Needs nothing else; define ASSERT_OFF to compile the checks out.
`ifndef SHARPEN_3X3_CROSS_STREAM_CORE_MACROS_SVH
`define SHARPEN_3X3_CROSS_STREAM_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define SHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define SHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/shp_pkg.sv =====
// Shared constants, register codes and inter-module structs for the sharpen core.
// Depends on nothing; shp_ifs, shp_ctrl, shp_calc and the top level import it.
package shp_pkg;

  // Sizing of the line stores
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int PIX_W        = $clog2(MAX_WIDTH);
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WEFF_W       = $clog2(MAX_WIDTH + 1);
  localparam int CEFF_W       = $clog2(MAX_CHANNELS + 1);

  // Field and register widths
  localparam int SAMPLE_W   = 8;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 12;
  localparam int CHAN_W     = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = SAMPLE_W + 4;

  // Kernel and reset values
  localparam int CENTRE_GAIN    = 5;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int CHANNELS_RESET = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2
  } cfg_reg_t;

  // Control for one transaction entering the arithmetic stage
  typedef struct packed {
    logic                emit;
    logic                zero;
    logic                row_end;
    logic                frame_end;
    logic                shift;
    logic                bank;
    logic [SAMPLE_W-1:0] down;
  } issue_t;

  // Line store access for one cycle
  typedef struct packed {
    logic [1:0]          we;
    logic                re;
    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [SAMPLE_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== rtl/shp_ifs.sv =====
// Valid/ready stream interfaces for the sharpen core input and result channels.
// Depends on shp_pkg for field widths.
interface shp_in_if import shp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

interface shp_out_if import shp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] out_value;
  logic                row_end;
  logic                frame_end;

  modport source (output valid, output out_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_value, input row_end, input frame_end,
                  output ready);
endinterface

// ===== rtl/shp_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Depends on nothing; read-before-write on a shared address.
module shp_ram #(
  parameter int DEPTH  = 8192,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr_a,
  input  logic [$clog2(DEPTH)-1:0] addr_b,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata_a,
  output logic [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write at port A address, both reads registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_a] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[addr_a];
      rdata_b <= mem[addr_b];
    end
  end

endmodule

// ===== rtl/shp_ctrl.sv =====
// Front end of the sharpen core: configuration registers, raster counters,
// line store addressing and per-transaction control. Depends on shp_pkg, shp_ifs.
module shp_ctrl import shp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  shp_in_if.sink                in_ch,
  input  logic                  s1_ready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output issue_t                issue,
  output logic                  issue_load,
  output ram_req_t              ram_req,
  output logic [CEFF_W-1:0]     chan_eff
);

  logic [WEFF_W-1:0]   w_eff_r;
  logic [HEIGHT_W-1:0] h_eff_r;
  logic [CEFF_W-1:0]   c_eff_r;
  logic [HEIGHT_W-1:0] row_r;
  logic [ADDR_W-1:0]   s_r;
  logic [PIX_W-1:0]    pix_r;
  logic [CH_W-1:0]     ch_r;
  logic                bank_r;

  logic                accept;
  logic                flush_phase;
  logic                last_pix;
  logic                last_ch;
  logic                last;
  logic                right_edge;
  logic                take_smp;
  logic                take_fl;
  logic                cfg_hit;
  logic [WEFF_W-1:0]   w_new;
  logic [HEIGHT_W-1:0] h_new;
  logic [CEFF_W-1:0]   c_new;

  assign in_ch.ready = s1_ready;
  assign chan_eff    = c_eff_r;

  // Clamp written values to their usable ranges
  always_comb begin
    if (cfg_data[WIDTH_W-1:0] == '0) begin
      w_new = WEFF_W'(1);
    end else if (int'(cfg_data[WIDTH_W-1:0]) > MAX_WIDTH) begin
      w_new = WEFF_W'(MAX_WIDTH);
    end else begin
      w_new = WEFF_W'(cfg_data[WIDTH_W-1:0]);
    end
    if (cfg_data[HEIGHT_W-1:0] == '0) begin
      h_new = HEIGHT_W'(1);
    end else begin
      h_new = cfg_data[HEIGHT_W-1:0];
    end
    if (cfg_data[CHAN_W-1:0] == '0) begin
      c_new = CEFF_W'(1);
    end else if (int'(cfg_data[CHAN_W-1:0]) > MAX_CHANNELS) begin
      c_new = CEFF_W'(MAX_CHANNELS);
    end else begin
      c_new = CEFF_W'(cfg_data[CHAN_W-1:0]);
    end
  end

  assign cfg_hit = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT) ||
                              (cfg_index == REG_CHANNELS));

  // Position decode for the current transaction
  always_comb begin
    accept      = in_ch.valid && s1_ready;
    flush_phase = (row_r >= h_eff_r);
    last_pix    = (WEFF_W'(pix_r) == w_eff_r - WEFF_W'(1));
    last_ch     = (CEFF_W'(ch_r) == c_eff_r - CEFF_W'(1));
    last        = last_pix && last_ch;
    right_edge  = (WEFF_W'(pix_r) + WEFF_W'(1) >= w_eff_r);
    take_smp    = accept && !in_ch.action && !flush_phase;
    take_fl     = accept && in_ch.action && flush_phase;
  end

  // Control handed to the arithmetic stage
  always_comb begin
    issue_load      = take_smp || take_fl;
    issue.emit      = take_fl || (row_r != '0);
    issue.zero      = take_fl || (row_r == HEIGHT_W'(1)) || (pix_r == '0) || right_edge;
    issue.row_end   = last;
    issue.frame_end = take_fl && last;
    issue.shift     = take_smp;
    issue.bank      = bank_r;
    issue.down      = in_ch.sample;
  end

  // Incoming row overwrites the upper bank; centre bank read at s and s+c
  always_comb begin
    ram_req.we[0]  = take_smp && !bank_r;
    ram_req.we[1]  = take_smp && bank_r;
    ram_req.re     = take_smp;
    ram_req.addr_a = s_r;
    ram_req.addr_b = s_r + ADDR_W'(c_eff_r);
    ram_req.wdata  = in_ch.sample;
  end

  // Configuration and raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WEFF_W'(WIDTH_RESET);
      h_eff_r <= HEIGHT_W'(HEIGHT_RESET);
      c_eff_r <= CEFF_W'(CHANNELS_RESET);
      row_r   <= '0;
      s_r     <= '0;
      pix_r   <= '0;
      ch_r    <= '0;
      bank_r  <= 1'b0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_WIDTH:    w_eff_r <= w_new;
        REG_HEIGHT:   h_eff_r <= h_new;
        REG_CHANNELS: c_eff_r <= c_new;
        default:      ;
      endcase
      row_r <= '0;
      s_r   <= '0;
      pix_r <= '0;
      ch_r  <= '0;
    end else if (take_smp || take_fl) begin
      if (last) begin
        s_r   <= '0;
        pix_r <= '0;
        ch_r  <= '0;
        if (take_smp) begin
          row_r  <= row_r + HEIGHT_W'(1);
          bank_r <= !bank_r;
        end else begin
          row_r <= '0;
        end
      end else begin
        s_r <= s_r + ADDR_W'(1);
        if (last_ch) begin
          ch_r  <= '0;
          pix_r <= pix_r + PIX_W'(1);
        end else begin
          ch_r <= ch_r + CH_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/shp_calc.sv =====
// Back end of the sharpen core: stage holding line store read data, left
// neighbor delay line, cross kernel with saturation and the result register.
// Depends on shp_pkg, shp_ifs and the assertion macros.
`include "sharpen_3x3_cross_stream_core_macros.svh"

module shp_calc import shp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  issue_t                     issue,
  input  logic                       issue_load,
  input  logic [CEFF_W-1:0]          chan_eff,
  input  logic [1:0][SAMPLE_W-1:0]   rd_a,
  input  logic [1:0][SAMPLE_W-1:0]   rd_b,
  output logic                       s1_ready,
  shp_out_if.source                  out_ch
);

  logic                s1_v_r;
  issue_t              s1_r;
  logic [SAMPLE_W-1:0] dline_r [MAX_CHANNELS];
  logic                out_v_r;
  logic [SAMPLE_W-1:0] out_val_r;
  logic                out_re_r;
  logic                out_fe_r;

  logic                s1_adv;
  logic                out_load;
  logic [SAMPLE_W-1:0] up_d;
  logic [SAMPLE_W-1:0] mid_c;
  logic [SAMPLE_W-1:0] mid_r;
  logic [SAMPLE_W-1:0] mid_l;
  logic [ACC_W-1:0]    pos_sum;
  logic [ACC_W-1:0]    neg_sum;
  logic [ACC_W-1:0]    acc;
  logic [SAMPLE_W-1:0] sat_val;

  // Stage handshake: a no-result transaction never waits on the output
  always_comb begin
    s1_adv   = s1_v_r && (!s1_r.emit || !out_v_r || out_ch.ready);
    s1_ready = !s1_v_r || s1_adv;
    out_load = s1_adv && s1_r.emit;
  end

  // Bank select: bank 0 means the older store is above the centre row
  always_comb begin
    up_d  = s1_r.bank ? rd_a[1] : rd_a[0];
    mid_c = s1_r.bank ? rd_a[0] : rd_a[1];
    mid_r = s1_r.bank ? rd_b[0] : rd_b[1];
    mid_l = dline_r[CH_W'(chan_eff - CEFF_W'(1))];
  end

  // 5*centre minus the four cross neighbors, clamped to the sample range; borders give zero
  always_comb begin
    pos_sum = ACC_W'(CENTRE_GAIN) * ACC_W'(mid_c);
    neg_sum = ACC_W'(up_d) + ACC_W'(s1_r.down) + ACC_W'(mid_l) + ACC_W'(mid_r);
    acc     = pos_sum - neg_sum;
    if (s1_r.zero || acc[ACC_W-1]) begin
      sat_val = '0;
    end else if (acc[ACC_W-2:SAMPLE_W] != '0) begin
      sat_val = '1;
    end else begin
      sat_val = acc[SAMPLE_W-1:0];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_value = out_val_r;
  assign out_ch.row_end   = out_re_r;
  assign out_ch.frame_end = out_fe_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (issue_load) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload: stage control, centre-row delay line, result register
  always_ff @(posedge clk) begin
    if (issue_load) begin
      s1_r <= issue;
    end
    if (s1_adv && s1_r.shift) begin
      dline_r[0] <= mid_c;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        dline_r[i] <= dline_r[i-1];
      end
    end
    if (out_load) begin
      out_val_r <= sat_val;
      out_re_r  <= s1_r.row_end;
      out_fe_r  <= s1_r.frame_end;
    end
  end

  `SHP_ASSERT_IMP(a_frame_end_on_row_end, clk, rst_n, out_v_r && out_fe_r, out_re_r, "frame end without row end")
  `SHP_ASSERT_NXT(a_stall_holds_both, clk, rst_n, s1_v_r && s1_r.emit && out_v_r && !out_ch.ready, s1_v_r && out_v_r, "stalled result lost")
  `SHP_ASSERT_NXT(a_border_is_zero, clk, rst_n, out_load && s1_r.zero, out_v_r && (out_val_r == '0), "border result not zero")
  `SHP_ASSERT_IMP(a_ready_only_on_full, clk, rst_n, !s1_ready, s1_v_r && s1_r.emit && out_v_r && !out_ch.ready, "input blocked without a full pipeline")

endmodule

// ===== rtl/sharpen_3x3_cross_stream_core.sv =====
// Streaming 3x3 cross sharpening filter, top level.
// Input channel: one 8-bit sample per transaction in raster order, channels of a
//   pixel interleaved; action 1 marks a flush transaction.
// Result channel: out_value with row_end and frame_end flags. Each sample of row r
//   (r >= 1) gives the result for the same place in row r-1; row 0 gives none.
//   After the last image row, one flush transaction per sample emits the zero row.
// Configuration: cfg_we/cfg_index/cfg_data write width, height or channel count
//   while idle; a write to any of these three restarts the frame at row 0.
// Path: an accepted transaction is registered in the read stage with its line store
//   read data; its result then goes into the result register once that is free.
// Throughput: one transaction per cycle while in_ch.ready is high, set by the two
//   line stores, each with one write port and two read ports (centre, right neighbor).
// Reset: counters clear and the registers return to 640 x 480 x 3; line store
//   contents are not cleared and need no clearing pass.
// Stall: the result register and the read stage buffer two transactions; in_ch.ready
//   falls only when both hold results and out_ch.ready is low.
// Depends on shp_pkg, shp_ifs, shp_ram, shp_ctrl, shp_calc.
module sharpen_3x3_cross_stream_core import shp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  shp_in_if.sink                in_ch,
  shp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  issue_t                   issue;
  logic                     issue_load;
  ram_req_t                 ram_req;
  logic [CEFF_W-1:0]        chan_eff;
  logic                     s1_ready;
  logic [1:0][SAMPLE_W-1:0] rd_a;
  logic [1:0][SAMPLE_W-1:0] rd_b;

  shp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .s1_ready   (s1_ready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .issue      (issue),
    .issue_load (issue_load),
    .ram_req    (ram_req),
    .chan_eff   (chan_eff)
  );

  // Ping-pong line stores
  shp_ram #(.DEPTH(STORE_DEPTH), .DATA_W(SAMPLE_W)) older_row_store (
    .clk     (clk),
    .we      (ram_req.we[0]),
    .re      (ram_req.re),
    .addr_a  (ram_req.addr_a),
    .addr_b  (ram_req.addr_b),
    .wdata   (ram_req.wdata),
    .rdata_a (rd_a[0]),
    .rdata_b (rd_b[0])
  );

  shp_ram #(.DEPTH(STORE_DEPTH), .DATA_W(SAMPLE_W)) prior_row_store (
    .clk     (clk),
    .we      (ram_req.we[1]),
    .re      (ram_req.re),
    .addr_a  (ram_req.addr_a),
    .addr_b  (ram_req.addr_b),
    .wdata   (ram_req.wdata),
    .rdata_a (rd_a[1]),
    .rdata_b (rd_b[1])
  );

  shp_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_load (issue_load),
    .chan_eff   (chan_eff),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .s1_ready   (s1_ready),
    .out_ch     (out_ch)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for sharpen_3x3_cross_stream_core: random and directed frames,
// predicted in-bench and compared result by result. Needs shp_pkg, shp_ifs and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shp_pkg::*;

  localparam int IDLE_PCT      = 14;
  localparam int RANDOM_ITEMS  = 560;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 5000;
  // Index past the register list: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                flush;
    logic [SAMPLE_W-1:0] sample;
  } pix_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                row_end;
    logic                frame_end;
  } sharp_out_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  shp_in_if  in_ch();
  shp_out_if out_ch();

  sharpen_3x3_cross_stream_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  pix_item_t  pending_items[$];
  sharp_out_t expected_outputs[$];

  // Predictor state: registers, line stores, bank select and position
  logic [WIDTH_W-1:0]  sh_width;
  logic [HEIGHT_W-1:0] sh_height;
  logic [CHAN_W-1:0]   sh_chans;
  logic [SAMPLE_W-1:0] line_a [STORE_DEPTH];
  logic [SAMPLE_W-1:0] line_b [STORE_DEPTH];
  bit                  bank_sel;
  int unsigned         row_now;
  int unsigned         pos_now;

  bit calm;
  int hold_requests;
  int holds_served;
  int hold_left;
  int mismatches;
  int stall_cycles;
  int fed_items;

  function automatic int unsigned width_eff();
    if (sh_width == 0) return 1;
    if (sh_width > MAX_WIDTH) return MAX_WIDTH;
    return sh_width;
  endfunction

  function automatic int unsigned height_eff();
    return (sh_height == 0) ? 1 : sh_height;
  endfunction

  function automatic int unsigned chans_eff();
    if (sh_chans == 0) return 1;
    if (sh_chans > MAX_CHANNELS) return MAX_CHANNELS;
    return sh_chans;
  endfunction

  function automatic int unsigned frame_total();
    return width_eff() * chans_eff() * (height_eff() + 1);
  endfunction

  // Sharpened value for one accepted transaction, advancing the frame position
  function automatic void sharpen_predict(pix_item_t it);
    int unsigned w, h, c, len, s, pix;
    bit last;
    int acc;
    logic [SAMPLE_W-1:0] up_v, mid_v, left_v, right_v;
    sharp_out_t res;
    w = width_eff();
    h = height_eff();
    c = chans_eff();
    len = w * c;
    s = pos_now;
    last = (s + 1 >= len);

    // Flush phase: zero last row, samples ignored
    if (row_now >= h) begin
      if (!it.flush) return;
      res = '{value: '0, row_end: last, frame_end: last};
      expected_outputs.push_back(res);
      if (last) begin
        row_now = 0;
        pos_now = 0;
      end else begin
        pos_now = s + 1;
      end
      return;
    end
    if (it.flush) return;

    // Row 0 gives nothing; later rows give the row above, borders zero
    if (row_now >= 1) begin
      res = '{value: '0, row_end: last, frame_end: 1'b0};
      pix = s / c;
      if (row_now != 1 && pix != 0 && pix + 1 < w) begin
        mid_v   = bank_sel ? line_a[s]     : line_b[s];
        up_v    = bank_sel ? line_b[s]     : line_a[s];
        left_v  = bank_sel ? line_a[s - c] : line_b[s - c];
        right_v = bank_sel ? line_a[s + c] : line_b[s + c];
        acc = CENTRE_GAIN * int'(mid_v) - int'(up_v) - int'(it.sample)
              - int'(left_v) - int'(right_v);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        res.value = acc[SAMPLE_W-1:0];
      end
      expected_outputs.push_back(res);
    end

    // Incoming row replaces the row above the centre
    if (bank_sel) line_b[s] = it.sample;
    else line_a[s] = it.sample;
    if (last) begin
      pos_now = 0;
      bank_sel = !bank_sel;
      row_now = row_now + 1;
    end else begin
      pos_now = s + 1;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Input driver: holds a transaction until taken, random gaps otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sharpen_predict(pending_items[0]);
        void'(pending_items.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid  <= 1'b1;
          in_ch.action <= pending_items[0].flush;
          in_ch.sample <= pending_items[0].sample;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure and requested long holds
  always @(posedge clk) begin : check_results
    sharp_out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outputs.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got value %0d row_end %0b frame_end %0b",
                   $time, out_ch.out_value, out_ch.row_end, out_ch.frame_end);
        end else begin
          want = expected_outputs.pop_front();
          if ({out_ch.out_value, out_ch.row_end, out_ch.frame_end} !== want) begin
            mismatches++;
            $display("%0t: expected value %0d row_end %0b frame_end %0b, got %0d %0b %0b",
                     $time, want.value, want.row_end, want.frame_end,
                     out_ch.out_value, out_ch.row_end, out_ch.frame_end);
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (holds_served < hold_requests) begin
        out_ch.ready <= 1'b0;
        holds_served <= holds_served + 1;
        hold_left <= LONG_HOLD;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Register write; the predictor follows once the block has taken it
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    bit known = 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:    sh_width  = data[WIDTH_W-1:0];
      REG_HEIGHT:   sh_height = data[HEIGHT_W-1:0];
      REG_CHANNELS: sh_chans  = data[CHAN_W-1:0];
      default:      known = 1'b0;
    endcase
    if (known) begin
      row_now = 0;
      pos_now = 0;
    end
    @(negedge clk);
  endtask

  // Wait for all transactions and results, then let rows 0 work finish
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_item(input logic flush, input logic [SAMPLE_W-1:0] smp);
    pix_item_t it;
    it.flush  = flush;
    it.sample = smp;
    pending_items.push_back(it);
  endtask

  // One frame plus its flush row; may stop early or pause for a full drain
  task automatic queue_frame(input int stop_at, input int pause_at, input bit poke_unused);
    int image_len, total;
    image_len = width_eff() * chans_eff() * height_eff();
    total = frame_total();
    for (int k = 0; k < total; k++) begin
      if (k == stop_at) break;
      if (k == pause_at) begin
        wait_drained();
        if (poke_unused) write_cfg(REG_UNUSED, $urandom_range(0, 4095));
      end
      // Stray transaction the block has to ignore
      if ($urandom_range(0, 99) < 3) push_item(k >= image_len ? 1'b0 : 1'b1, rand_sample());
      push_item(k >= image_len, rand_sample());
      fed_items++;
    end
  endtask

  task automatic pick_config();
    int unsigned w, h;
    wait_drained();
    case ($urandom_range(0, 9))
      0: w = 0;
      1: w = 1;
      2: w = 2;
      default: w = $urandom_range(3, 10);
    endcase
    case ($urandom_range(0, 5))
      0: h = 0;
      1: h = 1;
      default: h = $urandom_range(2, 6);
    endcase
    write_cfg(REG_WIDTH, w);
    if ($urandom_range(0, 3) != 0) write_cfg(REG_HEIGHT, h);
    if ($urandom_range(0, 3) != 0) write_cfg(REG_CHANNELS, $urandom_range(0, 7));
  endtask

  initial begin : stimulus
    int pass_no;
    int mode;
    int total;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    calm = 1'b0;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    mismatches = 0;
    stall_cycles = 0;
    fed_items = 0;
    sh_width = WIDTH_RESET;
    sh_height = HEIGHT_RESET;
    sh_chans = CHANNELS_RESET;
    bank_sel = 1'b0;
    row_now = 0;
    pos_now = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single row frame, two pixels wide, channel count left at its reset value
    write_cfg(REG_WIDTH, 2);
    write_cfg(REG_HEIGHT, 1);
    push_item(1'b1, 8'hFF);            // flush before the flush phase: ignored
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h55);
    push_item(1'b0, 8'hAA);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'hFF);            // sample during the flush phase: ignored
    repeat (6) push_item(1'b1, 8'h00);
    wait_drained();

    // 3x3 mono frame, centre saturates high
    write_cfg(REG_CHANNELS, 1);
    write_cfg(REG_WIDTH, 3);
    write_cfg(REG_HEIGHT, 3);
    for (int i = 0; i < 9; i++) push_item(1'b0, (i == 4) ? 8'hFF : 8'h00);
    repeat (3) push_item(1'b1, 8'h00);
    wait_drained();

    // Channel count above the limit acting as four; output side held off long
    // enough to fill the block
    write_cfg(REG_CHANNELS, 7);
    write_cfg(REG_WIDTH, 10);
    write_cfg(REG_HEIGHT, 4);
    queue_frame(-1, -1, 1'b0);
    hold_requests = hold_requests + 1;
    wait_drained();

    // Random frames: mostly whole, some cut short, some paused mid-frame
    fed_items = 0;
    pass_no = 0;
    while (fed_items < RANDOM_ITEMS) begin
      calm = (fed_items >= 300 && fed_items < 450);
      if (pass_no == 0 || $urandom_range(0, 2) == 0) pick_config();
      total = frame_total();
      mode = $urandom_range(0, 9);
      if (pass_no == 0) begin
        queue_frame(-1, total / 2, 1'b1);
      end else if (mode == 0) begin
        queue_frame($urandom_range(1, total - 1), -1, 1'b0);
        pick_config();
      end else if (mode == 1) begin
        queue_frame(-1, $urandom_range(1, total - 1), 1'b0);
      end else begin
        queue_frame(-1, -1, 1'b0);
      end
      pass_no++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/shp_pkg.sv
rtl/shp_ifs.sv
rtl/shp_ram.sv
rtl/shp_ctrl.sv
rtl/shp_calc.sv
rtl/sharpen_3x3_cross_stream_core.sv
dv/tb.sv
